@@ src/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h11;

  typedef enum logic [3:0] {
    ROLE_HDR1     = 4'd0,
    ROLE_HDR2     = 4'd1,
    ROLE_LENGTH   = 4'd2,
    ROLE_TYPEKEY  = 4'd3,
    ROLE_KEYLEN   = 4'd4,
    ROLE_KEY      = 4'd5,
    ROLE_COMID    = 4'd6,
    ROLE_PARAM    = 4'd7,
    ROLE_CHECKSUM = 4'd8,
    ROLE_IGNORED  = 4'd9
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_SHORT    = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_EMPTY    = 3'd4,
    ERR_KEY      = 3'd5,
    ERR_COMID    = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } rx_beat_t;

  typedef struct packed {
    role_t      byte_role;
    logic [7:0] byte_value;
    logic       frame_done;
    logic       frame_ok;
    err_t       error_code;
    logic [7:0] param_count;
    logic       is_secure;
  } result_beat_t;

endpackage

@@ src/rfd_if.sv @@
// ----------------------------------------------------------------------------
// rfd_if
// Valid/ready channels carrying received bytes and classified results.
// ----------------------------------------------------------------------------
interface rfd_rx_if;
  logic              valid;
  logic              ready;
  rfd_pkg::rx_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rfd_result_if;
  logic                  valid;
  logic                  ready;
  rfd_pkg::result_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/rpc_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// Streaming parser for 0xAA 0x11 length-prefixed frames with additive checksum.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, while results drain, and every
// byte yields exactly one result beat: the byte first lands in an input
// register, then one pass of the parser (an 8-bit add for the running sum, an
// 8-bit position compare and the phase decode) writes the result register.
// The result register sits apart from the input register, so a new byte is
// taken while an earlier result waits; ready drops only when both are full and
// the result side is stalled. The byte marked as buffer end returns the parser
// to expecting a first header byte.
module rpc_frame_deframer (
  input  logic                clk,
  input  logic                rst,
  rfd_rx_if.sink              byte_ch,
  rfd_result_if.source        result_ch
);

  typedef enum logic [8:0] {
    PH_HDR1    = 9'b000000001,
    PH_HDR2    = 9'b000000010,
    PH_LEN     = 9'b000000100,
    PH_TYPEKEY = 9'b000001000,
    PH_KEYLEN  = 9'b000010000,
    PH_KEY     = 9'b000100000,
    PH_COMID   = 9'b001000000,
    PH_PARAM   = 9'b010000000,
    PH_IGNORE  = 9'b100000000
  } phase_t;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // result register
  logic                  res_valid;
  rfd_pkg::result_beat_t res_data;

  // parser state
  phase_t        phase, phase_next;
  logic [7:0]    plen, plen_next;
  logic [7:0]    pos, pos_next;
  logic [7:0]    sum, sum_next;
  logic          secure, secure_next;
  logic [7:0]    kleft, kleft_next;
  rfd_pkg::err_t pend, pend_next;
  logic [7:0]    pcount, pcount_next;

  rfd_pkg::result_beat_t res_comb;
  logic                  adv;

  assign adv           = s1_valid && (!res_valid || result_ch.ready);
  assign byte_ch.ready = !s1_valid || adv;

  assign result_ch.valid = res_valid;
  assign result_ch.data  = res_data;

  always_comb begin
    rfd_pkg::role_t role;
    logic           done;
    rfd_pkg::err_t  err;
    logic [7:0]     kdec;

    role        = rfd_pkg::ROLE_IGNORED;
    done        = 1'b0;
    err         = rfd_pkg::ERR_NONE;
    kdec        = kleft - 8'd1;
    phase_next  = phase;
    plen_next   = plen;
    pos_next    = pos;
    sum_next    = sum;
    secure_next = secure;
    kleft_next  = kleft;
    pend_next   = pend;
    pcount_next = pcount;

    case (phase)
      PH_HDR1: begin
        role = rfd_pkg::ROLE_HDR1;
        if (s1_byte != rfd_pkg::HDR_FIRST) begin
          done       = 1'b1;
          err        = rfd_pkg::ERR_HEADER;
          phase_next = PH_IGNORE;
        end else begin
          phase_next = PH_HDR2;
        end
      end
      PH_HDR2: begin
        role = rfd_pkg::ROLE_HDR2;
        if (s1_byte != rfd_pkg::HDR_SECOND) begin
          done       = 1'b1;
          err        = rfd_pkg::ERR_HEADER;
          phase_next = PH_IGNORE;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        role       = rfd_pkg::ROLE_LENGTH;
        plen_next  = s1_byte;
        pos_next   = 8'd0;
        sum_next   = 8'd0;
        pend_next  = rfd_pkg::ERR_EMPTY;
        phase_next = PH_TYPEKEY;
      end
      PH_TYPEKEY, PH_KEYLEN, PH_KEY, PH_COMID, PH_PARAM: begin
        if (pos >= plen) begin
          role = rfd_pkg::ROLE_CHECKSUM;
          done = 1'b1;
          if (plen == 8'd0 && s1_last) begin
            err = rfd_pkg::ERR_SHORT;
          end else if (sum != s1_byte) begin
            err = rfd_pkg::ERR_CHECKSUM;
          end else begin
            err = pend;
          end
          phase_next = PH_IGNORE;
        end else begin
          sum_next = sum + s1_byte;
          pos_next = pos + 8'd1;
          case (phase)
            PH_TYPEKEY: begin
              role        = rfd_pkg::ROLE_TYPEKEY;
              secure_next = s1_byte[6];
              pend_next   = rfd_pkg::ERR_KEY;
              if (s1_byte[2]) begin
                phase_next = PH_KEYLEN;
              end else begin
                phase_next = PH_KEY;
                kleft_next = 8'd1;
              end
            end
            PH_KEYLEN: begin
              role       = rfd_pkg::ROLE_KEYLEN;
              kleft_next = s1_byte;
              if (s1_byte != 8'd0) begin
                phase_next = PH_KEY;
              end else if (secure) begin
                phase_next = PH_COMID;
                pend_next  = rfd_pkg::ERR_COMID;
              end else begin
                phase_next = PH_PARAM;
                pend_next  = rfd_pkg::ERR_NONE;
              end
            end
            PH_KEY: begin
              role       = rfd_pkg::ROLE_KEY;
              kleft_next = kdec;
              if (kdec == 8'd0) begin
                if (secure) begin
                  phase_next = PH_COMID;
                  pend_next  = rfd_pkg::ERR_COMID;
                end else begin
                  phase_next = PH_PARAM;
                  pend_next  = rfd_pkg::ERR_NONE;
                end
              end
            end
            PH_COMID: begin
              role       = rfd_pkg::ROLE_COMID;
              phase_next = PH_PARAM;
              pend_next  = rfd_pkg::ERR_NONE;
            end
            default: begin
              role        = rfd_pkg::ROLE_PARAM;
              pcount_next = pcount + 8'd1;
            end
          endcase
        end
      end
      default: begin
        role = rfd_pkg::ROLE_IGNORED;
      end
    endcase

    // buffer cut before the checksum byte
    if (s1_last && role != rfd_pkg::ROLE_CHECKSUM && role != rfd_pkg::ROLE_IGNORED) begin
      done = 1'b1;
      err  = rfd_pkg::ERR_SHORT;
    end

    res_comb.byte_role   = role;
    res_comb.byte_value  = s1_byte;
    res_comb.frame_done  = done;
    res_comb.frame_ok    = done && (err == rfd_pkg::ERR_NONE);
    res_comb.error_code  = err;
    res_comb.param_count = done ? pcount_next : 8'd0;
    res_comb.is_secure   = secure_next;

    // end of buffer restarts the parser
    if (s1_last) begin
      phase_next  = PH_HDR1;
      plen_next   = 8'd0;
      pos_next    = 8'd0;
      sum_next    = 8'd0;
      secure_next = 1'b0;
      kleft_next  = 8'd0;
      pend_next   = rfd_pkg::ERR_NONE;
      pcount_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      phase     <= PH_HDR1;
      plen      <= 8'd0;
      pos       <= 8'd0;
      sum       <= 8'd0;
      secure    <= 1'b0;
      kleft     <= 8'd0;
      pend      <= rfd_pkg::ERR_NONE;
      pcount    <= 8'd0;
    end else begin
      if (byte_ch.ready) begin
        s1_valid <= byte_ch.valid;
      end
      if (adv) begin
        res_valid <= 1'b1;
        phase     <= phase_next;
        plen      <= plen_next;
        pos       <= pos_next;
        sum       <= sum_next;
        secure    <= secure_next;
        kleft     <= kleft_next;
        pend      <= pend_next;
        pcount    <= pcount_next;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_byte <= byte_ch.data.rx_byte;
      s1_last <= byte_ch.data.buffer_end;
    end
    if (adv) begin
      res_data <= res_comb;
    end
  end

endmodule

@@ test/rpc_frame_deframer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_frame_deframer_test
// Self-checking bench for the frame deframer. Sends whole buffers (good
// frames, short payloads, bad checksums, cut buffers, bad headers, trailing
// bytes and noise). Every result beat is checked against a cycle-free model
// of the parser, first under directed cases and then under random idling,
// stalling and a long result-side hold-off.
// ----------------------------------------------------------------------------
module rpc_frame_deframer_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_CYCLES     = 10;

  typedef enum int {
    KIND_GOOD,
    KIND_TRAILING,
    KIND_CUT_LENGTH,
    KIND_BAD_SUM,
    KIND_TRUNCATED,
    KIND_BAD_HEADER,
    KIND_NOISE
  } frame_kind_t;

  logic clk;
  logic rst;

  rfd_rx_if     byte_ch();
  rfd_result_if result_ch();

  rpc_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  // parser model state
  rfd_pkg::role_t ph;
  logic [7:0]     model_len;
  logic [7:0]     payload_pos;
  logic [7:0]     run_sum;
  logic           long_key;
  logic           secure;
  logic [7:0]     key_left;
  rfd_pkg::err_t  pend_err;
  logic [7:0]     params_seen;

  rfd_pkg::result_beat_t predicted_beats[$];
  logic [7:0]            frame_bytes[$];
  logic [7:0]            payload_bytes[$];

  int idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;
  int mismatch_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser_state();
    ph          = rfd_pkg::ROLE_HDR1;
    model_len   = '0;
    payload_pos = '0;
    run_sum     = '0;
    long_key    = 1'b0;
    secure      = 1'b0;
    key_left    = '0;
    pend_err    = rfd_pkg::ERR_NONE;
    params_seen = '0;
  endfunction

  function automatic void enter_after_key();
    if (secure) begin
      ph       = rfd_pkg::ROLE_COMID;
      pend_err = rfd_pkg::ERR_COMID;
    end else begin
      ph       = rfd_pkg::ROLE_PARAM;
      pend_err = rfd_pkg::ERR_NONE;
    end
  endfunction

  function automatic rfd_pkg::result_beat_t classify_byte(input logic [7:0] b,
                                                          input logic last);
    rfd_pkg::result_beat_t r;
    rfd_pkg::role_t        role;
    logic                  done;
    logic                  ok;
    rfd_pkg::err_t         err;
    done = 1'b0;
    ok   = 1'b0;
    err  = rfd_pkg::ERR_NONE;
    if (ph > rfd_pkg::ROLE_PARAM) begin
      role = rfd_pkg::ROLE_IGNORED;
    end else if (ph == rfd_pkg::ROLE_HDR1 || ph == rfd_pkg::ROLE_HDR2) begin
      role = ph;
      if (b != (ph == rfd_pkg::ROLE_HDR1 ? rfd_pkg::HDR_FIRST : rfd_pkg::HDR_SECOND)) begin
        done = 1'b1;
        err  = rfd_pkg::ERR_HEADER;
        ph   = rfd_pkg::ROLE_IGNORED;
      end else begin
        ph = (ph == rfd_pkg::ROLE_HDR1) ? rfd_pkg::ROLE_HDR2 : rfd_pkg::ROLE_LENGTH;
      end
    end else if (ph == rfd_pkg::ROLE_LENGTH) begin
      role        = rfd_pkg::ROLE_LENGTH;
      model_len   = b;
      payload_pos = '0;
      run_sum     = '0;
      pend_err    = rfd_pkg::ERR_EMPTY;
      ph          = rfd_pkg::ROLE_TYPEKEY;
    end else if (payload_pos >= model_len) begin
      role = rfd_pkg::ROLE_CHECKSUM;
      done = 1'b1;
      if (model_len == 8'd0 && last) err = rfd_pkg::ERR_SHORT;
      else if (run_sum != b) err = rfd_pkg::ERR_CHECKSUM;
      else err = pend_err;
      ok = (err == rfd_pkg::ERR_NONE);
      ph = rfd_pkg::ROLE_IGNORED;
    end else begin
      role        = ph;
      run_sum     = run_sum + b;
      payload_pos = payload_pos + 8'd1;
      case (ph)
        rfd_pkg::ROLE_TYPEKEY: begin
          long_key = b[2];
          secure   = b[6];
          pend_err = rfd_pkg::ERR_KEY;
          if (long_key) begin
            ph = rfd_pkg::ROLE_KEYLEN;
          end else begin
            ph       = rfd_pkg::ROLE_KEY;
            key_left = 8'd1;
          end
        end
        rfd_pkg::ROLE_KEYLEN: begin
          key_left = b;
          if (b == 8'd0) enter_after_key();
          else ph = rfd_pkg::ROLE_KEY;
        end
        rfd_pkg::ROLE_KEY: begin
          key_left = key_left - 8'd1;
          if (key_left == 8'd0) enter_after_key();
        end
        rfd_pkg::ROLE_COMID: begin
          ph       = rfd_pkg::ROLE_PARAM;
          pend_err = rfd_pkg::ERR_NONE;
        end
        default: params_seen = params_seen + 8'd1;
      endcase
    end
    // buffer mark before the checksum byte cuts the frame short
    if (last && role != rfd_pkg::ROLE_CHECKSUM && role != rfd_pkg::ROLE_IGNORED) begin
      done = 1'b1;
      ok   = 1'b0;
      err  = rfd_pkg::ERR_SHORT;
    end
    r.byte_role   = role;
    r.byte_value  = b;
    r.frame_done  = done;
    r.frame_ok    = ok;
    r.error_code  = err;
    r.param_count = done ? params_seen : 8'd0;
    r.is_secure   = secure;
    if (last) clear_parser_state();
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    rfd_pkg::rx_beat_t beat;
    beat.rx_byte    = b;
    beat.buffer_end = last;
    while ($urandom_range(99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= beat;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predicted_beats.push_back(classify_byte(b, last));
  endtask

  task automatic send_frame_bytes();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic pause_until_drained();
    byte_ch.valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
  endtask

  task automatic build_frame(input frame_kind_t kind);
    logic [7:0] tk;
    logic [7:0] sum;
    logic [7:0] plen;
    logic       big_frame;
    int         klen;
    int         npar;
    int         cut;
    int         idx;
    payload_bytes.delete();
    frame_bytes.delete();
    if (kind == KIND_NOISE) begin
      frame_bytes.push_back($urandom_range(1) ? rfd_pkg::HDR_FIRST : 8'($urandom));
      repeat ($urandom_range(11)) frame_bytes.push_back(8'($urandom));
    end else begin
      big_frame = ($urandom_range(59) == 0);
      tk    = 8'($urandom);
      tk[2] = 1'($urandom_range(1));
      tk[6] = 1'($urandom_range(1));
      payload_bytes.push_back(tk);
      klen = 1;
      if (tk[2]) begin
        klen = big_frame ? $urandom_range(250) : $urandom_range(6);
        payload_bytes.push_back(8'(klen));
      end
      repeat (klen) payload_bytes.push_back(8'($urandom));
      if (tk[6]) payload_bytes.push_back(8'($urandom));
      npar = big_frame ? 255 - payload_bytes.size() : $urandom_range(8);
      repeat (npar) payload_bytes.push_back(8'($urandom));
      plen = 8'(payload_bytes.size());
      if (kind == KIND_CUT_LENGTH) plen = 8'($urandom_range(payload_bytes.size()));
      sum = '0;
      frame_bytes.push_back(rfd_pkg::HDR_FIRST);
      frame_bytes.push_back(rfd_pkg::HDR_SECOND);
      frame_bytes.push_back(plen);
      for (int i = 0; i < plen; i++) begin
        sum = sum + payload_bytes[i];
        frame_bytes.push_back(payload_bytes[i]);
      end
      if (kind == KIND_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(sum);
      if (kind == KIND_BAD_HEADER) begin
        idx = $urandom_range(1);
        frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      if (kind == KIND_TRUNCATED) begin
        cut = $urandom_range(frame_bytes.size() - 2);
        while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
      end
      if (kind == KIND_TRAILING) begin
        repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic test_good_frames();
    idle_pct  = 0;
    stall_pct = 0;
    // short key, no command id
    frame_bytes = '{8'hAA, 8'h11, 8'h02, 8'h01, 8'h5A, 8'h5B};
    send_frame_bytes();
    // secure, zero-length long key, command id and two params
    frame_bytes = '{8'hAA, 8'h11, 8'h05, 8'h44, 8'h00, 8'hC3, 8'h09, 8'hF0, 8'h00};
    send_frame_bytes();
    pause_until_drained();
  endtask

  task automatic test_header_errors();
    frame_bytes = '{8'h55, 8'hFF};
    send_frame_bytes();
    frame_bytes = '{8'hAA, 8'h10, 8'h00};
    send_frame_bytes();
    pause_until_drained();
  endtask

  task automatic test_structure_errors();
    // empty payload, mark after the checksum byte
    frame_bytes = '{8'hAA, 8'h11, 8'h00, 8'h00, 8'h7F};
    send_frame_bytes();
    // empty payload, mark on the checksum byte
    frame_bytes = '{8'hAA, 8'h11, 8'h00, 8'h00};
    send_frame_bytes();
    // payload ends before the key length
    frame_bytes = '{8'hAA, 8'h11, 8'h01, 8'h04, 8'h04};
    send_frame_bytes();
    // secure frame ends before the command id
    frame_bytes = '{8'hAA, 8'h11, 8'h02, 8'h44, 8'h00, 8'h44};
    send_frame_bytes();
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                     input int n_bytes);
    int          sent;
    int          pick;
    frame_kind_t kind;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    sent      = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 55) kind = KIND_GOOD;
      else if (pick < 65) kind = KIND_TRAILING;
      else if (pick < 75) kind = KIND_CUT_LENGTH;
      else if (pick < 83) kind = KIND_BAD_SUM;
      else if (pick < 91) kind = KIND_TRUNCATED;
      else if (pick < 95) kind = KIND_BAD_HEADER;
      else kind = KIND_NOISE;
      build_frame(kind);
      send_frame_bytes();
      sent += frame_bytes.size();
    end
    pause_until_drained();
  endtask

  task automatic test_backpressure();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 300;
    repeat (6) begin
      build_frame(KIND_GOOD);
      send_frame_bytes();
    end
    pause_until_drained();
  endtask

  always @(posedge clk) begin : result_check
    rfd_pkg::result_beat_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (predicted_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: role %0d value %h",
                   result_ch.data.byte_role, result_ch.data.byte_value);
      end else begin
        want = predicted_beats.pop_front();
        if (result_ch.data.byte_role !== want.byte_role ||
            result_ch.data.byte_value !== want.byte_value ||
            result_ch.data.frame_done !== want.frame_done ||
            result_ch.data.frame_ok !== want.frame_ok ||
            result_ch.data.error_code !== want.error_code ||
            result_ch.data.param_count !== want.param_count ||
            result_ch.data.is_secure !== want.is_secure) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch exp/got: role %0d/%0d value %h/%h done %b/%b ok %b/%b",
                      " err %0d/%0d params %0d/%0d secure %b/%b"},
                     want.byte_role, result_ch.data.byte_role,
                     want.byte_value, result_ch.data.byte_value,
                     want.frame_done, result_ch.data.frame_done,
                     want.frame_ok, result_ch.data.frame_ok,
                     want.error_code, result_ch.data.error_code,
                     want.param_count, result_ch.data.param_count,
                     want.is_secure, result_ch.data.is_secure);
        end
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.data    = '0;
    result_ch.ready = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_request    = 0;
    hold_left       = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    clear_parser_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_good_frames();
    test_header_errors();
    test_structure_errors();
    test_random_traffic(0, 0, 400);
    test_random_traffic(86, 0, 400);
    test_random_traffic(0, 86, 400);
    test_random_traffic(16, 16, 400);
    test_backpressure();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
